@@ rtl/sfr_pkg.sv @@
`timescale 1ns / 1ps

package sfr_pkg;

   // default frame store depth in bytes
   localparam int BUFFER_BYTES_DEF = 16;

   // framing characters
   localparam logic [7:0] SYNC_BYTE = 8'h5B;
   localparam logic [7:0] STOP_BYTE = 8'h5D;

   // result kinds
   localparam logic [1:0] KIND_BODY      = 2'd0;
   localparam logic [1:0] KIND_DISCOVERY = 2'd1;
   localparam logic [1:0] KIND_TX        = 2'd2;

   // completed good frame handed from parser to emitter
   typedef struct packed {
      logic       valid;
      logic       discovery;
      logic [7:0] len;
   } frame_done_type;

endpackage

@@ rtl/sfr_ram.sv @@
`timescale 1ns / 1ps

module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sfr_parser.sv @@
`timescale 1ns / 1ps

module sfr_parser #(
   parameter int BUFFER_BYTES = sfr_pkg::BUFFER_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            byte_valid,
   input  logic [7:0]                      rx_byte,
   output logic                            wr_en,
   output logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
   output logic [7:0]                      wr_data,
   output sfr_pkg::frame_done_type         done
);

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam logic [8:0] BufLimit = 9'(BUFFER_BYTES);

   logic          in_frame_ff, in_frame_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] len_ff, len_in;
   logic [7:0]    sum_ff, sum_in;
   logic [AW-1:0] len_cur;
   logic          too_long;
   logic          complete;

   // length of the current frame, taken straight from the word on the length byte
   assign len_cur  = (fill_ff == '0) ? rx_byte[AW-1:0] : len_ff;
   assign too_long = (fill_ff == '0) && ({1'b0, rx_byte} >= BufLimit);
   assign complete = (fill_ff == len_cur);

   // frame bytes go into the store at the fill position
   assign wr_en   = byte_valid && in_frame_ff && !too_long;
   assign wr_addr = fill_ff;
   assign wr_data = rx_byte;

   // hunt, fill and checksum tracking
   always_comb begin
      in_frame_in    = in_frame_ff;
      fill_in        = fill_ff;
      len_in         = len_ff;
      sum_in         = sum_ff;
      done.valid     = 1'b0;
      done.discovery = (len_cur == '0);
      done.len       = 8'(len_cur);
      if (byte_valid) begin
         if (!in_frame_ff) begin
            in_frame_in = (rx_byte == sfr_pkg::SYNC_BYTE);
            fill_in     = '0;
            sum_in      = '0;
         end else if (too_long) begin
            in_frame_in = 1'b0;
            fill_in     = '0;
            sum_in      = '0;
         end else if (complete) begin
            // checksum byte: good frame if the sum matches and the length is not one (empty body)
            done.valid  = (sum_ff == rx_byte) && (len_cur != AW'(1));
            in_frame_in = 1'b0;
            fill_in     = '0;
            sum_in      = '0;
         end else begin
            len_in  = len_cur;
            sum_in  = sum_ff + rx_byte;
            fill_in = fill_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         fill_ff     <= '0;
         sum_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
      end
      len_ff <= len_in;
   end

endmodule

@@ rtl/sfr_emitter.sv @@
`timescale 1ns / 1ps

module sfr_emitter #(
   parameter int BUFFER_BYTES = sfr_pkg::BUFFER_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sfr_pkg::frame_done_type         done,
   input  logic [31:0]                     mode_tag,
   output logic                            busy,
   output logic                            rd_en,
   output logic [$clog2(BUFFER_BYTES)-1:0] rd_addr,
   input  logic [7:0]                      rd_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [1:0]                      out_kind,
   output logic [7:0]                      out_data,
   output logic                            out_last
);

   localparam int AW = $clog2(BUFFER_BYTES);

   // discovery reply steps
   localparam logic [2:0] STEP_EVENT = 3'd0;
   localparam logic [2:0] STEP_OPEN  = 3'd1;
   localparam logic [2:0] STEP_TAG0  = 3'd2;
   localparam logic [2:0] STEP_TAG1  = 3'd3;
   localparam logic [2:0] STEP_TAG2  = 3'd4;
   localparam logic [2:0] STEP_TAG3  = 3'd5;
   localparam logic [2:0] STEP_CLOSE = 3'd6;

   logic          busy_ff, busy_in;
   logic          disc_ff, disc_in;
   logic          more_ff, more_in;
   logic [AW-1:0] len_ff, len_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [2:0]    step_ff, step_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          last_pend_ff, last_pend_in;
   logic          out_valid_ff, out_valid_in;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    data_ff, data_in;
   logic          last_ff, last_in;

   logic          fire;
   logic          out_free;
   logic          issue;
   logic          load_body;
   logic          load_disc;
   logic          idx_last;
   logic [1:0]    disc_kind;
   logic [7:0]    disc_data;

   assign fire      = out_valid_ff && out_ready;
   assign out_free  = !out_valid_ff || fire;
   assign load_body = rd_pend_ff && out_free;
   assign issue     = busy_ff && !disc_ff && more_ff && (!rd_pend_ff || out_free);
   assign load_disc = busy_ff && disc_ff && more_ff && out_free;
   assign idx_last  = (idx_ff == len_ff - AW'(1));

   assign rd_en   = issue;
   assign rd_addr = idx_ff;

   // discovery reply contents
   always_comb begin
      disc_kind = sfr_pkg::KIND_TX;
      disc_data = 8'h00;
      case (step_ff)
         STEP_EVENT: begin
            disc_kind = sfr_pkg::KIND_DISCOVERY;
            disc_data = 8'h00;
         end
         STEP_OPEN:  disc_data = sfr_pkg::SYNC_BYTE;
         STEP_TAG0:  disc_data = mode_tag[7:0];
         STEP_TAG1:  disc_data = mode_tag[15:8];
         STEP_TAG2:  disc_data = mode_tag[23:16];
         STEP_TAG3:  disc_data = mode_tag[31:24];
         STEP_CLOSE: disc_data = sfr_pkg::STOP_BYTE;
         default:    disc_data = 8'h00;
      endcase
   end

   // read-ahead sequencer with output register
   always_comb begin
      busy_in      = busy_ff;
      disc_in      = disc_ff;
      more_in      = more_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      rd_pend_in   = rd_pend_ff;
      last_pend_in = last_pend_ff;
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      data_in      = data_ff;
      last_in      = last_ff;

      if (fire) begin
         out_valid_in = 1'b0;
         if (last_ff) begin
            busy_in = 1'b0;
         end
      end

      if (load_body) begin
         out_valid_in = 1'b1;
         kind_in      = sfr_pkg::KIND_BODY;
         data_in      = rd_data;
         last_in      = last_pend_ff;
         rd_pend_in   = 1'b0;
      end

      if (issue) begin
         rd_pend_in   = 1'b1;
         last_pend_in = idx_last;
         more_in      = !idx_last;
         idx_in       = idx_ff + AW'(1);
      end

      if (load_disc) begin
         out_valid_in = 1'b1;
         kind_in      = disc_kind;
         data_in      = disc_data;
         last_in      = (step_ff == STEP_CLOSE);
         more_in      = (step_ff != STEP_CLOSE);
         step_in      = step_ff + 3'd1;
      end

      if (done.valid && !busy_ff) begin
         busy_in = 1'b1;
         disc_in = done.discovery;
         len_in  = done.len[AW-1:0];
         idx_in  = AW'(1);
         step_in = STEP_EVENT;
         more_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         more_ff      <= 1'b0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         more_ff      <= more_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
      disc_ff      <= disc_in;
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      step_ff      <= step_in;
      last_pend_ff <= last_pend_in;
      kind_ff      <= kind_in;
      data_ff      <= data_in;
      last_ff      <= last_in;
   end

   assign busy      = busy_ff;
   assign out_valid = out_valid_ff;
   assign out_kind  = kind_ff;
   assign out_data  = data_ff;
   assign out_last  = last_ff;

endmodule

@@ rtl/serial_frame_receiver_core.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  req_tdata = rx_byte
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata = data, rsp_tuser = kind, rsp_tlast = last
// csr       in   csr_wen                csr_wdata = mode_tag
//
// A received byte is taken when req_tvalid and req_tready are both high; bytes that finish
// no good frame cause no result. A good frame's checksum byte starts the emitter: body bytes
// are read from the frame store through its registered read port, one per cycle while rsp
// is not stalled; a discovery reply gives 7 results at the same rate. req_tready stays low
// until the last result of the frame is taken. Reset is synchronous; the frame store needs
// no clearing. A stall on rsp holds the output word and pauses the store reads.

module serial_frame_receiver_core #(
   parameter int BUFFER_BYTES = sfr_pkg::BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata    // [31:0] mode_tag
);

   localparam int AW = $clog2(BUFFER_BYTES);

   logic                    mode_tag_ff;
   logic [31:0]             mode_tag_q_ff;
   logic                    emit_busy;
   logic                    byte_valid;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [7:0]              wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [7:0]              rd_data;
   sfr_pkg::frame_done_type done;

   // mode tag register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_tag_q_ff <= '0;
         mode_tag_ff   <= 1'b0;
      end else if (csr_wen) begin
         mode_tag_q_ff <= csr_wdata;
         mode_tag_ff   <= 1'b1;
      end
   end

   assign req_tready = !emit_busy;
   assign byte_valid = req_tvalid && req_tready;

   sfr_parser #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_tdata),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .done       (done)
   );

   sfr_ram #(
      .WIDTH(8),
      .DEPTH(BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfr_emitter #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .done      (done),
      .mode_tag  (mode_tag_ff ? mode_tag_q_ff : 32'h0),
      .busy      (emit_busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_data  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

@@ rtl/sfr_checker.sv @@
`timescale 1ns / 1ps

module sfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // no new byte is taken while results are still pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while results pending");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // discovery event carries zero data and is never the last result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == sfr_pkg::KIND_DISCOVERY) |-> !rsp_tlast && (rsp_tdata == 8'h00))
      else $error("malformed discovery event");

   // only defined kinds appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == sfr_pkg::KIND_BODY) || (rsp_tuser == sfr_pkg::KIND_DISCOVERY)
         || (rsp_tuser == sfr_pkg::KIND_TX))
      else $error("undefined result kind");

endmodule

bind serial_frame_receiver_core sfr_checker u_sfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/rx_frame_checker.sv @@
`timescale 1ns / 1ps

module rx_frame_checker
   import sfr_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] data
   input  logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata,   // [31:0] mode_tag
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } rsp_word_type;

   // shadow of the receiver state
   logic        in_frame;
   logic [4:0]  fill_count;
   logic [7:0]  frame_sum;
   logic [7:0]  frame_bytes [0:BUFFER_BYTES-1];
   logic [31:0] mode_tag;

   rsp_word_type expected_words [$];
   int mismatches = 0;
   int queued = 0;

   assign fail_count = mismatches;
   assign pending    = queued;

   task automatic queue_word(input logic [1:0] kind, input logic [7:0] data);
      rsp_word_type w;
      w.kind = kind;
      w.data = data;
      w.last = 1'b0;
      expected_words.push_back(w);
   endtask

   task automatic start_hunting();
      in_frame   = 1'b0;
      fill_count = '0;
      frame_sum  = '0;
   endtask

   // work out the words caused by one received byte
   task automatic predict_rx_byte(input logic [7:0] b);
      logic [7:0] len;
      int first;
      int i;
      first = expected_words.size();
      if (!in_frame) begin
         if (b == SYNC_BYTE) in_frame = 1'b1;
         fill_count = '0;
         frame_sum  = '0;
         return;
      end
      // length that cannot fit the store
      if (fill_count == 0 && int'(b) + 1 > BUFFER_BYTES) begin
         start_hunting();
         return;
      end
      if (int'(fill_count) >= BUFFER_BYTES) begin
         start_hunting();
         return;
      end
      frame_bytes[fill_count] = b;
      len = frame_bytes[0];
      if (int'(fill_count) < int'(len)) frame_sum = frame_sum + b;
      fill_count = fill_count + 5'd1;
      if (int'(fill_count) != int'(len) + 1) return;
      // frame complete, checksum byte is the last stored
      if (frame_sum == frame_bytes[len]) begin
         if (len == 0) begin
            queue_word(KIND_DISCOVERY, 8'h00);
            queue_word(KIND_TX, SYNC_BYTE);
            for (i = 0; i < 4; i++) queue_word(KIND_TX, mode_tag[8*i +: 8]);
            queue_word(KIND_TX, STOP_BYTE);
         end else begin
            for (i = 1; i < int'(len); i++) queue_word(KIND_BODY, frame_bytes[i]);
         end
         if (expected_words.size() > first)
            expected_words[expected_words.size() - 1].last = 1'b1;
      end
      start_hunting();
   endtask

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         start_hunting();
         mode_tag = '0;
         expected_words.delete();
      end else begin
         if (csr_wen) mode_tag = csr_wdata;
         if (req_tvalid && req_tready) predict_rx_byte(req_tdata);
         // compare each delivered word with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: kind %0d, data %0h, last %0d",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_tuser !== w.kind) begin
                  $error("field kind: expected %0d, actual %0d", w.kind, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata !== w.data) begin
                  $error("field data: expected %0h, actual %0h", w.data, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== w.last) begin
                  $error("field last: expected %0d, actual %0d", w.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
      queued = expected_words.size();
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import sfr_pkg::*;

   localparam int MAX_IDLE      = 13;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wen    = 1'b0;
   logic [31:0] csr_wdata  = '0;

   int fail_count;
   int pending;
   int bytes_sent = 0;
   int hold_asked = 0;
   int hold_done  = 0;
   bit quiet      = 1'b0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   serial_frame_receiver_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   rx_frame_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // offer one byte after a random gap, return at the edge that takes it
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // sync, length, random body and checksum, optionally spoilt
   task automatic send_frame(input int len, input bit corrupt);
      logic [7:0] sum;
      logic [7:0] b;
      int i;
      sum = len[7:0];
      send_byte(SYNC_BYTE);
      send_byte(len[7:0]);
      for (i = 1; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         sum = sum + b;
         send_byte(b);
      end
      // a zero length byte is the whole frame
      if (len != 0) begin
         if (corrupt) sum = sum + 8'($urandom_range(1, 255));
         send_byte(sum);
      end
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return 0;
      if (r < 22) return BUFFER_BYTES_DEF - 1;
      return $urandom_range(1, BUFFER_BYTES_DEF - 1);
   endfunction

   // mostly good frames, the rest broken frames and line noise
   task automatic random_frames(input int budget);
      int base;
      int r;
      int n;
      logic [7:0] b;
      base = bytes_sent;
      while (bytes_sent - base < budget) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            send_frame(pick_length(), 1'b0);
         end else if (r < 80) begin
            send_frame($urandom_range(1, BUFFER_BYTES_DEF - 1), 1'b1);
         end else if (r < 90) begin
            send_byte(SYNC_BYTE);
            send_byte(8'($urandom_range(BUFFER_BYTES_DEF, 255)));
         end else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               if (b == SYNC_BYTE) b = b ^ 8'h01;
               send_byte(b);
            end
         end
      end
   endtask

   // drop valid and wait until every predicted word has been delivered
   task automatic settle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode_tag(input logic [31:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // sender
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_mode_tag(32'h5AA5_FF00);

      // noise while hunting
      send_byte(8'h00);
      send_byte(8'hFF);
      // discovery request
      send_byte(SYNC_BYTE);
      send_byte(8'h00);
      // empty body, good checksum
      send_byte(SYNC_BYTE);
      send_byte(8'h01);
      send_byte(8'h01);
      // sync byte carried as body
      send_byte(SYNC_BYTE);
      send_byte(8'h02);
      send_byte(SYNC_BYTE);
      send_byte(8'h5D);
      // bad checksum
      send_byte(SYNC_BYTE);
      send_byte(8'h02);
      send_byte(8'hFF);
      send_byte(8'h00);
      // lengths too large for the store
      send_byte(SYNC_BYTE);
      send_byte(8'(BUFFER_BYTES_DEF));
      send_byte(SYNC_BYTE);
      send_byte(8'hFF);
      // largest frame that fits
      send_frame(BUFFER_BYTES_DEF - 1, 1'b0);
      settle();

      // long receiver hold-off during a discovery reply
      write_mode_tag($urandom);
      hold_asked++;
      send_frame(0, 1'b0);
      random_frames(45);
      settle();

      // no idling on either side
      write_mode_tag(32'h0000_0000);
      quiet = 1'b1;
      random_frames(35);
      quiet = 1'b0;
      settle();

      write_mode_tag(32'hFFFF_FFFF);
      random_frames(45);
      settle();

      if (fail_count == 0 && pending == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // receiver
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_asked != hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done++;
         end
         stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
